### rtl/bst_pkg.sv
// ============================================================================
// bst_pkg: build script tokenizer shared definitions
// Types, constants, keyword table and position helpers used by the scanner,
// the token queue and the top level.
// ============================================================================
package bst_pkg;

    // Sizing
    localparam int MAX_VALUE_LEN = 1023;
    localparam int OFFSET_BITS   = 24;
    localparam int OUT_OFFSET_W  = 24;
    localparam int POS_W         = 16;
    localparam int LEN_W         = $clog2(MAX_VALUE_LEN + 2);
    localparam int KW_COUNT      = 5;
    localparam int KW_MAX_LEN    = 10;
    localparam int KW_IDX_W      = $clog2(KW_MAX_LEN);

    // Token queue, depth must be a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Stream widths
    localparam int TDATA_BITS = 2 * OUT_OFFSET_W + 4 * POS_W + 8 + 1;
    localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;
    localparam int TUSER_W    = 4;

    // Characters with special meaning
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef logic [OFFSET_BITS-1:0]  offset_t;
    typedef logic [OUT_OFFSET_W-1:0] out_offset_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic [LEN_W-1:0]        len_t;
    typedef logic [KW_COUNT-1:0]     kw_hits_t;

    typedef enum logic [3:0] {
        KIND_IDENT      = 4'd0,
        KIND_COMPONENT  = 4'd1,
        KIND_EXECUTABLE = 4'd2,
        KIND_STATIC     = 4'd3,
        KIND_LINK       = 4'd4,
        KIND_TEST       = 4'd5,
        KIND_STRING     = 4'd6,
        KIND_UNCLOSED   = 4'd7,
        KIND_SEMI       = 4'd8,
        KIND_COLON      = 4'd9,
        KIND_END        = 4'd10,
        KIND_ERROR      = 4'd11
    } token_kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_SLASH   = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_NAME    = 5'b01000,
        MODE_STRING  = 5'b10000
    } scan_mode_t;

    typedef struct packed {
        offset_t offset;
        pos_t    line;
        pos_t    column;
    } position_t;

    typedef struct packed {
        token_kind_t kind;
        out_offset_t start_offset;
        pos_t        start_line;
        pos_t        start_column;
        out_offset_t end_offset;
        pos_t        end_line;
        pos_t        end_column;
        logic [7:0]  bad_byte;
        logic        too_long;
        logic        last;
    } token_t;

    // Up to two tokens produced by one text byte; valid1 implies valid0
    typedef struct packed {
        logic   valid0;
        logic   valid1;
        token_t tok0;
        token_t tok1;
    } emit_t;

    // Keyword spelling and length
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"c", "o", "m", "p", "o", "n", "e", "n", "t", 8'h00},
        '{"e", "x", "e", "c", "u", "t", "a", "b", "l", "e"},
        '{"s", "t", "a", "t", "i", "c", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "i", "n", "k", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "e", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam len_t KW_LEN [KW_COUNT] = '{
        LEN_W'(9), LEN_W'(10), LEN_W'(6), LEN_W'(4), LEN_W'(4)
    };

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b == "_");
    endfunction

    function automatic logic is_name_char(input logic [7:0] b);
        return is_alpha(b) || (b >= "0" && b <= "9");
    endfunction

    function automatic pos_t sat_pos(input pos_t v);
        return (v == '1) ? v : v + POS_W'(1);
    endfunction

    function automatic offset_t sat_off(input offset_t v);
        return (v == '1) ? v : v + OFFSET_BITS'(1);
    endfunction

    // Position after consuming byte b
    function automatic position_t advance(input position_t p, input logic [7:0] b);
        position_t r;
        r        = p;
        r.offset = sat_off(p.offset);
        if (b == CH_NL)
        begin
            r.line   = sat_pos(p.line);
            r.column = '0;
        end
        else
        begin
            r.column = sat_pos(p.column);
        end
        return r;
    endfunction

    // Token spanning start to end
    function automatic token_t span_tok(input token_kind_t kind, input position_t s,
                                        input position_t e, input logic [7:0] bad,
                                        input logic tl);
        token_t t;
        t.kind         = kind;
        t.start_offset = OUT_OFFSET_W'(s.offset);
        t.start_line   = s.line;
        t.start_column = s.column;
        t.end_offset   = OUT_OFFSET_W'(e.offset);
        t.end_line     = e.line;
        t.end_column   = e.column;
        t.bad_byte     = bad;
        t.too_long     = tl;
        t.last         = 1'b0;
        return t;
    endfunction

    // One-byte token at position p
    function automatic token_t single_tok(input token_kind_t kind, input position_t p,
                                          input logic [7:0] bad);
        position_t e;
        e        = p;
        e.offset = sat_off(p.offset);
        e.column = sat_pos(p.column);
        return span_tok(kind, p, e, bad, 1'b0);
    endfunction

endpackage

### rtl/bst_scan.sv
// ============================================================================
// bst_scan: tokenizer scan state and per-byte step logic
// Holds mode, position, token start and keyword match; on each step it
// consumes one text byte and produces zero, one or two tokens.
// ============================================================================
module bst_scan
    import bst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] text_byte,
    output emit_t      emit
);

    scan_mode_t mode_reg, mode_next;
    position_t  cur_reg, cur_next;
    position_t  start_reg, start_next;
    kw_hits_t   hits_reg, hits_next;
    len_t       len_reg, len_next;

    position_t   adv_pos;
    logic        name_cont;
    kw_hits_t    base_hits, add_hits;
    len_t        base_len, add_len, cnt_len;
    token_kind_t close_kind;
    logic        len_over;
    logic        idle_run;
    logic        pre_valid, post_valid;
    token_t      pre_tok, post_tok;

    // Name character bookkeeping: keyword filter and saturating length
    always_comb
    begin
        name_cont = (mode_reg == MODE_NAME) && is_name_char(text_byte);
        base_hits = name_cont ? hits_reg : '1;
        base_len  = name_cont ? len_reg : '0;
        add_hits  = base_hits;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (base_hits[k] && ((base_len >= KW_LEN[k]) ||
                (KW_TEXT[k][base_len[KW_IDX_W-1:0]] != text_byte)))
            begin
                add_hits[k] = 1'b0;
            end
        end
        add_len = (base_len <= LEN_W'(MAX_VALUE_LEN)) ? base_len + LEN_W'(1) : base_len;
        cnt_len = (len_reg <= LEN_W'(MAX_VALUE_LEN)) ? len_reg + LEN_W'(1) : len_reg;
        len_over = (len_reg > LEN_W'(MAX_VALUE_LEN));
    end

    // Keyword lookup when a name closes; lowest index wins
    always_comb
    begin
        close_kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (hits_reg[k] && (len_reg == KW_LEN[k]))
            begin
                close_kind = token_kind_t'(4'(k + 1));
            end
        end
    end

    // Step: mode-specific handling, then the idle rules when they apply
    always_comb
    begin
        adv_pos    = advance(cur_reg, text_byte);
        mode_next  = mode_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        hits_next  = hits_reg;
        len_next   = len_reg;
        idle_run   = 1'b0;
        pre_valid  = 1'b0;
        pre_tok    = single_tok(KIND_ERROR, start_reg, CH_SLASH);
        post_valid = 1'b0;
        post_tok   = single_tok(KIND_END, cur_reg, CH_NUL);

        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (text_byte == CH_SLASH)
                begin
                    mode_next = MODE_COMMENT;
                    cur_next  = adv_pos;
                end
                else
                begin
                    // lone slash becomes an error at its own position
                    pre_valid = 1'b1;
                    idle_run  = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (text_byte == CH_NUL)
                begin
                    idle_run = 1'b1;
                end
                else
                begin
                    cur_next = adv_pos;
                    if (text_byte == CH_NL)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_NAME:
            begin
                if (name_cont)
                begin
                    hits_next = add_hits;
                    len_next  = add_len;
                    cur_next  = adv_pos;
                end
                else
                begin
                    pre_valid = 1'b1;
                    pre_tok   = span_tok(len_over ? KIND_IDENT : close_kind, start_reg,
                                         cur_reg, CH_NUL, len_over);
                    idle_run  = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (text_byte == CH_QUOTE)
                begin
                    cur_next  = adv_pos;
                    pre_valid = 1'b1;
                    pre_tok   = span_tok(KIND_STRING, start_reg, adv_pos, CH_NUL, len_over);
                    mode_next = MODE_IDLE;
                end
                else if (text_byte == CH_NUL)
                begin
                    pre_valid = 1'b1;
                    pre_tok   = span_tok(KIND_UNCLOSED, start_reg, cur_reg, CH_NUL, len_over);
                    idle_run  = 1'b1;
                end
                else
                begin
                    len_next = cnt_len;
                    cur_next = adv_pos;
                end
            end
            default:
            begin
                idle_run = 1'b1;
            end
        endcase

        // Between tokens
        if (idle_run)
        begin
            mode_next = MODE_IDLE;
            if (text_byte == CH_NUL)
            begin
                // end of text is not consumed
                post_valid = 1'b1;
                post_tok   = single_tok(KIND_END, cur_reg, CH_NUL);
            end
            else if (is_space(text_byte))
            begin
                cur_next = adv_pos;
            end
            else if (text_byte == CH_SLASH)
            begin
                start_next = cur_reg;
                len_next   = '0;
                hits_next  = '1;
                mode_next  = MODE_SLASH;
                cur_next   = adv_pos;
            end
            else if (text_byte == CH_QUOTE)
            begin
                // string value starts just past the quote
                start_next = adv_pos;
                len_next   = '0;
                hits_next  = '1;
                mode_next  = MODE_STRING;
                cur_next   = adv_pos;
            end
            else if (text_byte == CH_SEMI || text_byte == CH_COLON)
            begin
                post_valid = 1'b1;
                post_tok   = single_tok((text_byte == CH_SEMI) ? KIND_SEMI : KIND_COLON,
                                        cur_reg, CH_NUL);
                cur_next   = adv_pos;
            end
            else if (is_alpha(text_byte))
            begin
                start_next = cur_reg;
                hits_next  = add_hits;
                len_next   = add_len;
                mode_next  = MODE_NAME;
                cur_next   = adv_pos;
            end
            else
            begin
                post_valid = 1'b1;
                post_tok   = single_tok(KIND_ERROR, cur_reg, text_byte);
                cur_next   = adv_pos;
            end
        end
    end

    // Order the tokens and mark the last one of this byte
    always_comb
    begin
        emit.valid0 = step_en && (pre_valid || post_valid);
        emit.valid1 = step_en && pre_valid && post_valid;
        emit.tok0   = pre_valid ? pre_tok : post_tok;
        emit.tok1   = post_tok;
        emit.tok0.last = !(pre_valid && post_valid);
        emit.tok1.last = 1'b1;
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            cur_reg.offset   <= '0;
            cur_reg.line     <= POS_W'(1);
            cur_reg.column   <= '0;
            start_reg.offset <= '0;
            start_reg.line   <= POS_W'(1);
            start_reg.column <= '0;
            hits_reg         <= '1;
            len_reg          <= '0;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            cur_reg   <= cur_next;
            start_reg <= start_next;
            hits_reg  <= hits_next;
            len_reg   <= len_next;
        end
    end

endmodule

### rtl/bst_tok_fifo.sv
// ============================================================================
// bst_tok_fifo: result token queue
// Small register queue that takes up to two tokens per cycle and hands out
// one per cycle to the output stream while pop is asserted.
// ============================================================================
module bst_tok_fifo
    import bst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  emit_t                 push,
    input  logic                  pop,
    output token_t                head,
    output logic                  head_valid,
    output logic [FIFO_CNT_W-1:0] level
);

    token_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] level_reg, level_next;
    logic [FIFO_CNT_W-1:0] push_cnt;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;

    // Pointer and fill level update
    always_comb
    begin
        push_cnt     = FIFO_CNT_W'(push.valid0) + FIFO_CNT_W'(push.valid1);
        wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next  = rd_ptr_reg + FIFO_PTR_W'(pop);
        level_next   = level_reg + push_cnt - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Token storage
    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            mem[wr_ptr_reg] <= push.tok0;
        end
        if (push.valid1)
        begin
            mem[wr_ptr_plus1] <= push.tok1;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign level      = level_reg;

endmodule

### rtl/build_script_tokenizer.sv
// ============================================================================
// build_script_tokenizer: streaming build script tokenizer
// Scans source text one byte per transaction and streams out tokens with
// start and end positions.
// ============================================================================
// Usage:
//   Input stream s_*: one text byte per transaction in s_tdata[7:0]; a zero
//   byte marks end of text and yields an end token (scanning then continues
//   at the same position).
//   Output stream m_*: one token per transaction; m_tuser carries the token
//   kind, m_tlast marks the final token caused by one input byte.
//   Path: an accepted byte is held in an input register and scanned from it;
//   its tokens are written into the token queue and offered from there.
//   Throughput: one byte per cycle while the queue has room. A byte yields
//   zero, one or two tokens; the output side drains one token per cycle while
//   m_tready is high, from a four-entry queue, and a byte is scanned only when
//   two entries are free, so a stalled receiver backs up into s_tready.
//   Reset clears position to offset 0, line 1, column 0, returns the scanner
//   to idle and empties the token queue.
// ============================================================================
module build_script_tokenizer
    import bst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] text_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [23:0] start_offset, [39:24] start_line, [55:40] start_column,
    // [79:56] end_offset, [95:80] end_line, [111:96] end_column,
    // [119:112] bad_byte, [120] too_long, rest zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [TUSER_W-1:0] m_tuser,   // [3:0] token_kind
    output logic               m_tlast    // last_of_run
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  step_en;
    emit_t                 emit;
    token_t                head;
    logic                  head_valid;
    logic [FIFO_CNT_W-1:0] level;
    logic                  pop;

    // Input register; scan only when the queue has room for two tokens
    assign step_en  = in_valid_reg && (level <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    bst_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .text_byte (in_byte_reg),
        .emit      (emit)
    );

    assign pop = head_valid && m_tready;

    bst_tok_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .level      (level)
    );

    // Output packing
    assign m_tvalid = head_valid;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {(TDATA_W - TDATA_BITS)'(0), head.too_long, head.bad_byte,
                       head.end_column, head.end_line, head.end_offset,
                       head.start_column, head.start_line, head.start_offset};

    // Checks
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("token queue over full");

    a_room_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid0 |-> (level <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("tokens produced without queue room");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid1 |-> (emit.valid0 && !emit.tok0.last))
        else $error("second token without a first");

    a_held_token: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("queued token changed while stalled");

endmodule
